/* rtl/core/lswc_pkg.sv */
// Shared types, constants and helper functions of the LED-strip window compositor.
package lswc_pkg;

  localparam int NUM_W           = 9;
  localparam int IDX_W           = 8;
  localparam int COLOR_W         = 8;
  localparam int RGB_W           = 3 * COLOR_W;
  localparam int MAX_PIXELS_DEF  = 256;
  localparam int NUM_RESET       = 256;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int SETTLE_W        = 3;
  localparam int SETTLE_CYCLES   = 4;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_WINDOW = 2'd1,
    OP_MERGE  = 2'd2,
    OP_READ   = 2'd3
  } lswc_op_e;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_MERGE,
    KIND_READ
  } lswc_kind_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } lswc_state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [IDX_W-1:0]   seg_offset;
    logic [IDX_W-1:0]   window_start;
    logic [NUM_W-1:0]   window_length;
    logic               upward;
    logic               or_mode;
  } lswc_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_red;
    logic [COLOR_W-1:0] read_green;
    logic [COLOR_W-1:0] read_blue;
  } lswc_out_t;

  // Work item handed from the front end to the back end.
  typedef struct packed {
    lswc_kind_e       kind;
    logic             upward;
    logic             or_mode;
    logic             in_range;
    logic [NUM_W-1:0] pos;
    logic [NUM_W-1:0] base;
    logic [RGB_W-1:0] rgb;
  } lswc_cmd_t;

  typedef struct packed {
    logic init_busy;
  } lswc_back_stat_t;

  // (a + b) mod n for a, b below n.
  function automatic logic [NUM_W-1:0] mod_add(input logic [NUM_W-1:0] a,
                                               input logic [NUM_W-1:0] b,
                                               input logic [NUM_W-1:0] n);
    logic [NUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[NUM_W-1:0];
  endfunction

  // (a - b) mod n for a, b below n.
  function automatic logic [NUM_W-1:0] mod_sub(input logic [NUM_W-1:0] a,
                                               input logic [NUM_W-1:0] b,
                                               input logic [NUM_W-1:0] n);
    logic [NUM_W-1:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a + (n - b);
    end
    return r;
  endfunction

  function automatic logic [NUM_W-1:0] sat_index(input logic [NUM_W-1:0] v,
                                                 input logic [NUM_W-1:0] n);
    logic [NUM_W-1:0] top;
    top = n - NUM_W'(1);
    return (v > top) ? top : v;
  endfunction

  function automatic logic [NUM_W-1:0] sat_length(input logic [NUM_W-1:0] v,
                                                  input logic [NUM_W-1:0] n);
    logic [NUM_W-1:0] r;
    if (v == '0) begin
      r = NUM_W'(1);
    end else if (v > n) begin
      r = n;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/core/led_strip_window_compositor_core.sv */
// Top level of the LED-strip window compositor: front end, command queue and back end.
// An accepted read passes the command queue; the back end loads its result in EXEC.
// The back end handles a merge or read as one RAM read, then the write or the result
// load on the single store port; a clear sweeps every store address.
// After a window setup or a length write, full stays high while derived values settle.
// After reset the store is swept to zero while full is high.
module led_strip_window_compositor_core #(
  parameter int MAX_PIXELS  = lswc_pkg::MAX_PIXELS_DEF,
  parameter int QUEUE_DEPTH = lswc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lswc_pkg::NUM_W-1:0]  cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  lswc_pkg::lswc_in_t          in_data_i,
  output logic                        empty,
  input  logic                        pop,
  output lswc_pkg::lswc_out_t         out_data_o
);
  import lswc_pkg::*;

  logic             q_push, q_full, q_pop, q_empty;
  lswc_cmd_t        q_in, q_head;
  lswc_back_stat_t  stat;
  logic [NUM_W-1:0] n;

  lswc_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_o      (full),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .stat_i      (stat),
    .q_push_o    (q_push),
    .q_cmd_o     (q_in),
    .n_o         (n)
  );

  lswc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .empty_o (q_empty)
  );

  lswc_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .n_i        (n),
    .q_empty_i  (q_empty),
    .q_cmd_i    (q_head),
    .q_pop_o    (q_pop),
    .stat_o     (stat),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_data_o (out_data_o)
  );

  // The front end never pushes into a full command queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("command pushed into full queue");

  // No item is taken while the store is being swept after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) stat.init_busy |-> full)
    else $error("input open during reset sweep");

  // A new read is issued only into an empty result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (pop && !empty) |=> empty)
    else $error("result register reloaded while occupied");

  // A length write holds the input closed while derived window values settle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cfg_valid_i && cfg_ready_o) |=> full)
    else $error("input open right after a length write");

endmodule

/* rtl/core/lswc_ram.sv */
// Generic single-port RAM with registered read data.
module lswc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/lswc_queue.sv */
// Small command queue between the front end and the back end.
module lswc_queue #(
  parameter int DEPTH = lswc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lswc_pkg::lswc_cmd_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output lswc_pkg::lswc_cmd_t data_o,
  output logic                empty_o
);
  import lswc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lswc_cmd_t       mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/core/lswc_front.sv */
// Front end: strip length register, track window, and classification of input items.
module lswc_front #(
  parameter int MAX_PIXELS = lswc_pkg::MAX_PIXELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lswc_pkg::NUM_W-1:0]    cfg_data_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  lswc_pkg::lswc_in_t            in_data_i,
  input  logic                          q_full_i,
  input  lswc_pkg::lswc_back_stat_t     stat_i,
  output logic                          q_push_o,
  output lswc_pkg::lswc_cmd_t           q_cmd_o,
  output logic [lswc_pkg::NUM_W-1:0]    n_o
);
  import lswc_pkg::*;

  localparam int NUM_MAX = (1 << NUM_W) - 1;
  localparam int NCAP    = (MAX_PIXELS > NUM_MAX) ? NUM_MAX : MAX_PIXELS;
  localparam int NRST    = (MAX_PIXELS < NUM_RESET) ? MAX_PIXELS : NUM_RESET;

  logic [NUM_W-1:0]    num_q, n_q, n_d;
  logic [NUM_W-1:0]    win_off_q, win_start_q, win_len_q;
  logic                win_up_q, win_or_q;
  logic [NUM_W-1:0]    off_c_q, start_c_q, len_c_q;
  logic [NUM_W-1:0]    pixstart_q, pixend_q;
  logic [SETTLE_W-1:0] settle_q, settle_d;

  logic             accept, cfg_write, win_write, want_push;
  logic [NUM_W-1:0] idx9, k;
  logic             idx_ok, in_win;
  lswc_cmd_t        cmd;

  // Derived window values settle through a short register chain; the input
  // stays full until they are consistent with the latest window or length.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign full_o      = q_full_i | stat_i.init_busy | cfg_valid_i | (settle_q != '0);
  assign accept      = push_i & ~full_o;
  assign win_write   = accept && (in_data_i.opcode == OP_WINDOW);
  assign n_o         = n_q;

  always_comb begin
    if (num_q == '0) begin
      n_d = NUM_W'(1);
    end else if (num_q > NUM_W'(NCAP)) begin
      n_d = NUM_W'(NCAP);
    end else begin
      n_d = num_q;
    end
  end

  always_comb begin
    settle_d = settle_q;
    if (cfg_write || win_write) begin
      settle_d = SETTLE_W'(SETTLE_CYCLES);
    end else if (settle_q != '0) begin
      settle_d = settle_q - SETTLE_W'(1);
    end
  end

  always_comb begin
    idx9   = {{(NUM_W - IDX_W){1'b0}}, in_data_i.pixel_index};
    idx_ok = (idx9 < n_q);
    k      = mod_sub(idx9, start_c_q, n_q);
    in_win = idx_ok && (k < len_c_q);

    cmd          = '0;
    cmd.kind     = KIND_MERGE;
    cmd.upward   = win_up_q;
    cmd.or_mode  = win_or_q;
    cmd.in_range = idx_ok;
    cmd.pos      = k;
    cmd.base     = win_up_q ? pixstart_q : pixend_q;
    cmd.rgb      = {in_data_i.red, in_data_i.green, in_data_i.blue};
    want_push    = 1'b0;
    case (in_data_i.opcode)
      OP_CLEAR: begin
        cmd.kind  = KIND_CLEAR;
        want_push = 1'b1;
      end
      OP_MERGE: begin
        want_push = in_win;
      end
      OP_READ: begin
        cmd.kind  = KIND_READ;
        cmd.pos   = idx9;
        want_push = 1'b1;
      end
      default: begin
        want_push = 1'b0;
      end
    endcase
  end

  assign q_push_o = accept & want_push;
  assign q_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= NUM_W'(NRST);
      n_q         <= NUM_W'(NRST);
      win_off_q   <= '0;
      win_start_q <= '0;
      win_len_q   <= NUM_W'(NRST);
      win_up_q    <= 1'b1;
      win_or_q    <= 1'b1;
      off_c_q     <= '0;
      start_c_q   <= '0;
      len_c_q     <= NUM_W'(NRST);
      pixstart_q  <= '0;
      pixend_q    <= '0;
      settle_q    <= SETTLE_W'(SETTLE_CYCLES);
    end else begin
      if (cfg_write) begin
        num_q <= cfg_data_i;
      end
      if (win_write) begin
        win_off_q   <= sat_index({{(NUM_W - IDX_W){1'b0}}, in_data_i.seg_offset}, n_q);
        win_start_q <= sat_index({{(NUM_W - IDX_W){1'b0}}, in_data_i.window_start}, n_q);
        win_len_q   <= sat_length(in_data_i.window_length, n_q);
        win_up_q    <= in_data_i.upward;
        win_or_q    <= in_data_i.or_mode;
      end
      n_q        <= n_d;
      off_c_q    <= sat_index(win_off_q, n_q);
      start_c_q  <= sat_index(win_start_q, n_q);
      len_c_q    <= sat_length(win_len_q, n_q);
      pixstart_q <= mod_add(off_c_q, start_c_q, n_q);
      pixend_q   <= mod_add(pixstart_q, len_c_q - NUM_W'(1), n_q);
      settle_q   <= settle_d;
    end
  end

endmodule

/* rtl/core/lswc_back.sv */
// Back end: display store sweeps, merge read-modify-writes and pixel reads.
module lswc_back #(
  parameter int MAX_PIXELS = lswc_pkg::MAX_PIXELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lswc_pkg::NUM_W-1:0]   n_i,
  input  logic                         q_empty_i,
  input  lswc_pkg::lswc_cmd_t          q_cmd_i,
  output logic                         q_pop_o,
  output lswc_pkg::lswc_back_stat_t    stat_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output lswc_pkg::lswc_out_t          out_data_o
);
  import lswc_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam logic [AW-1:0] LAST = AW'(MAX_PIXELS - 1);

  lswc_state_e      state_q, state_d;
  logic [AW-1:0]    sweep_q, sweep_d;
  logic [AW-1:0]    addr_q, addr_d;
  lswc_cmd_t        cmd_q, cmd_d;
  logic             out_valid_q, out_valid_d;
  lswc_out_t        out_q, out_d;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [RGB_W-1:0] ram_wdata, ram_rdata;
  logic [NUM_W-1:0] dest, head_pos;
  logic [AW+NUM_W-1:0] head_wide;
  logic [AW-1:0]    head_addr;
  logic             sweep_done;

  assign dest      = q_cmd_i.upward ? mod_add(q_cmd_i.base, q_cmd_i.pos, n_i)
                                    : mod_sub(q_cmd_i.base, q_cmd_i.pos, n_i);
  assign head_pos  = (q_cmd_i.kind == KIND_MERGE) ? dest : q_cmd_i.pos;
  assign head_wide = {{AW{1'b0}}, head_pos};
  assign head_addr = head_wide[AW-1:0];
  assign sweep_done = (sweep_q == LAST);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        if (sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          case (q_cmd_i.kind)
            KIND_CLEAR: state_d = ST_CLEAR;
            KIND_MERGE: state_d = ST_EXEC;
            KIND_READ: begin
              if (!out_valid_q) begin
                state_d = ST_EXEC;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and handshake outputs.
  always_comb begin
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = head_addr;
    ram_wdata   = '0;
    sweep_d     = sweep_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~pop_i;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = sweep_q;
        sweep_d  = sweep_q + AW'(1);
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          case (q_cmd_i.kind)
            KIND_CLEAR: begin
              q_pop_o = 1'b1;
              sweep_d = '0;
            end
            KIND_MERGE: begin
              q_pop_o = 1'b1;
            end
            KIND_READ: begin
              q_pop_o = ~out_valid_q;
            end
            default: q_pop_o = 1'b0;
          endcase
          cmd_d  = q_cmd_i;
          addr_d = head_addr;
        end
      end
      ST_EXEC: begin
        ram_addr = addr_q;
        case (cmd_q.kind)
          KIND_MERGE: begin
            ram_we    = cmd_q.or_mode | (cmd_q.rgb != '0);
            ram_wdata = cmd_q.or_mode ? (ram_rdata | cmd_q.rgb) : cmd_q.rgb;
          end
          KIND_READ: begin
            out_valid_d = 1'b1;
            out_d       = lswc_out_t'(cmd_q.in_range ? ram_rdata : '0);
          end
          default: ram_we = 1'b0;
        endcase
      end
      default: ram_we = 1'b0;
    endcase
  end

  lswc_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cmd_q  <= cmd_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.init_busy = (state_q == ST_INIT);
  assign empty_o          = ~out_valid_q;
  assign out_data_o       = out_q;

endmodule
